FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the setpoint quantizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

FILE: hw/rtl/adc_sq_pkg.sv
// Package of widths, register indexes and sequencer states for the setpoint quantizer.
`default_nettype none

package adc_sq_pkg;

    // Bits of the ADC sample that take part in the filter.
    localparam int SAMPLE_BITS = 12;

    // Fixed field and register widths.
    localparam int IN_W       = 12;
    localparam int LEVEL_W    = 12;
    localparam int ORDER_W    = 5;
    localparam int STEP_W     = 12;
    localparam int SETP_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Divider sizing: the dividend holds sample + (order - 1) * level,
    // the divisor holds either the order or the ADC step.
    localparam int DVD_W  = SAMPLE_BITS + ORDER_W;
    localparam int DIV_W  = (STEP_W > ORDER_W) ? STEP_W : ORDER_W;
    localparam int CNT_W  = $clog2(DVD_W + 1);
    localparam int PROD_W = SETP_W + DVD_W;

    // Register reset values.
    localparam logic [ORDER_W-1:0] ORDER_RST = ORDER_W'(8);
    localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(128);
    localparam logic [SETP_W-1:0]  SETP_RST  = SETP_W'(100);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ORDER  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ADC_STEP      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_STEP = CFG_IDX_W'(2);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_DIV1  = 7'b0000100,
        S_QUANT = 7'b0001000,
        S_DIV2  = 7'b0010000,
        S_SCALE = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/adc_smoothing_setpoint_quantizer_unit.sv
// Potentiometer ADC smoother and setpoint quantizer with a shared bit-serial divider.
// A request passes through the load, first division, quantise, second division, scale and
// emit states on its way to the result register; each division runs DVD_W = 17 divider steps.
// A new request is taken only once the block is back in idle; a result held up behind a
// stalled output register keeps the block in its emit state until that register frees.
// Reset (synchronous, i_rst_n low): registers take their defaults, filter and last setpoint
// clear to zero, and no result is pending.
`default_nettype none

`include "assert_macros.svh"

module adc_smoothing_setpoint_quantizer_unit (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Sample request channel
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire  [adc_sq_pkg::IN_W-1:0]        i_sample,
    // Setpoint result channel
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [adc_sq_pkg::SETP_W-1:0]      o_setpoint,
    output logic [adc_sq_pkg::LEVEL_W-1:0]     o_smoothed_level,
    // Configuration write channel
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [adc_sq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [adc_sq_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import adc_sq_pkg::*;

    // Sequencer state and control registers.
    t_state               r_state,        n_state;
    logic [ORDER_W-1:0]   r_order,        n_order;
    logic [STEP_W-1:0]    r_adc_step,     n_adc_step;
    logic [SETP_W-1:0]    r_setp_step,    n_setp_step;
    logic [SAMPLE_BITS-1:0] r_filtered,   n_filtered;
    logic [SETP_W-1:0]    r_last,         n_last;
    logic                 r_out_valid,    n_out_valid;

    // Payload and datapath registers.
    logic [SAMPLE_BITS-1:0] r_sample,     n_sample;
    logic [DVD_W-1:0]     r_quo,          n_quo;
    logic [DIV_W-1:0]     r_rem,          n_rem;
    logic [DIV_W-1:0]     r_divisor,      n_divisor;
    logic [CNT_W-1:0]     r_cnt,          n_cnt;
    logic [PROD_W-1:0]    r_prod,         n_prod;
    logic [SETP_W-1:0]    r_out_setp,     n_out_setp;
    logic [LEVEL_W-1:0]   r_out_level,    n_out_level;

    // Combinational helpers.
    logic                 w_in_accept;
    logic [ORDER_W-1:0]   w_order;
    logic [DVD_W-1:0]     w_weighted;
    logic [DVD_W-1:0]     w_sum;
    logic [STEP_W-1:0]    w_step;
    logic [SAMPLE_BITS-1:0] w_level;
    logic [DVD_W-1:0]     w_qdvd;
    logic [DVD_W-1:0]     w_count;
    logic [SETP_W-1:0]    w_setpoint;
    logic                 w_out_free;
    logic                 w_emit;
    logic [DIV_W:0]       w_trial;
    logic [DIV_W:0]       w_diff;
    logic                 w_ge;
    logic                 w_div_last;

    // The block is busy from acceptance until the result has been judged and,
    // where it changed, placed in the output register.
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;

    // A zero order behaves as one, so the sample passes straight through.
    assign w_order    = (r_order == '0) ? ORDER_W'(1) : r_order;
    assign w_weighted = DVD_W'(ORDER_W'(w_order - ORDER_W'(1))) * DVD_W'(r_filtered);
    assign w_sum      = DVD_W'(r_sample) + w_weighted;

    // A zero ADC step behaves as one. Ceiling division is done as
    // (level + step - 1) / step on the same divider.
    assign w_step  = (r_adc_step == '0) ? STEP_W'(1) : r_adc_step;
    assign w_level = r_quo[SAMPLE_BITS-1:0];
    assign w_qdvd  = DVD_W'(w_level) + DVD_W'(w_step) - DVD_W'(1);

    // The lowest stair is one step, even for a level of zero.
    assign w_count    = (r_quo == '0) ? DVD_W'(1) : r_quo;
    assign w_setpoint = (|r_prod[PROD_W-1:SETP_W]) ? {SETP_W{1'b1}} : r_prod[SETP_W-1:0];

    // The output register may be refilled when empty or when its result
    // leaves in this same cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = (r_state == S_EMIT) && (w_setpoint != r_last) && w_out_free;

    // One restoring divider step: shift in the next dividend bit and
    // subtract the divisor where it fits.
    assign w_trial    = {r_rem, r_quo[DVD_W-1]};
    assign w_diff     = w_trial - {1'b0, r_divisor};
    assign w_ge       = (w_trial >= {1'b0, r_divisor});
    assign w_div_last = (r_cnt == CNT_W'(1));

    always_comb begin
        n_state     = r_state;
        n_order     = r_order;
        n_adc_step  = r_adc_step;
        n_setp_step = r_setp_step;
        n_filtered  = r_filtered;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_sample    = r_sample;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_divisor   = r_divisor;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_out_setp  = r_out_setp;
        n_out_level = r_out_level;

        // Configuration is only written while the block is idle.
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FILTER_ORDER:  n_order     = i_cfg_data[ORDER_W-1:0];
                REG_ADC_STEP:      n_adc_step  = i_cfg_data[STEP_W-1:0];
                REG_SETPOINT_STEP: n_setp_step = i_cfg_data[SETP_W-1:0];
                default:           ;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_sample = SAMPLE_BITS'(i_sample);
                    n_state  = S_LOAD;
                end
            end
            S_LOAD: begin
                // Weighted sum of the new sample and the previous level
                // becomes the first dividend.
                n_quo     = w_sum;
                n_rem     = '0;
                n_divisor = DIV_W'(w_order);
                n_cnt     = CNT_W'(DVD_W);
                n_state   = S_DIV1;
            end
            S_DIV1, S_DIV2: begin
                n_rem = w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], w_ge};
                n_cnt = r_cnt - CNT_W'(1);
                if (w_div_last) begin
                    n_state = (r_state == S_DIV1) ? S_QUANT : S_SCALE;
                end
            end
            S_QUANT: begin
                n_filtered = w_level;
                n_quo      = w_qdvd;
                n_rem      = '0;
                n_divisor  = DIV_W'(w_step);
                n_cnt      = CNT_W'(DVD_W);
                n_state    = S_DIV2;
            end
            S_SCALE: begin
                n_prod  = PROD_W'(r_setp_step) * PROD_W'(w_count);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_setpoint == r_last) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_setp  = w_setpoint;
                    n_out_level = LEVEL_W'(r_filtered);
                    n_last      = w_setpoint;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, configuration and filter memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_order     <= ORDER_RST;
            r_adc_step  <= STEP_RST;
            r_setp_step <= SETP_RST;
            r_filtered  <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_order     <= n_order;
            r_adc_step  <= n_adc_step;
            r_setp_step <= n_setp_step;
            r_filtered  <= n_filtered;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath and result payload.
    always_ff @(posedge i_clk) begin
        r_sample    <= n_sample;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_divisor   <= n_divisor;
        r_cnt       <= n_cnt;
        r_prod      <= n_prod;
        r_out_setp  <= n_out_setp;
        r_out_level <= n_out_level;
    end

    assign o_out_valid      = r_out_valid;
    assign o_setpoint       = r_out_setp;
    assign o_smoothed_level = r_out_level;

    // The remainder stays below the divisor throughout both divisions.
    `ASSERT_PROP(a_rem_below_div, i_clk, i_rst_n, ((r_state == S_DIV1) || (r_state == S_DIV2)) |-> (r_rem < r_divisor), "divider remainder reached the divisor")

    // A new result always carries the setpoint now held as the last one given.
    `ASSERT_PROP(a_emit_tracks_last, i_clk, i_rst_n, w_emit |=> (o_out_valid && (o_setpoint == r_last)), "emitted setpoint differs from last setpoint")

    // An accepted request always starts the sequencer.
    `ASSERT_PROP(a_accept_starts, i_clk, i_rst_n, w_in_accept |=> (r_state == S_LOAD), "accepted request did not start the sequencer")

    // A pending result is never overwritten while the consumer stalls.
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, w_emit && r_out_valid && i_out_stall, "pending result overwritten")

endmodule

`default_nettype wire
